[sv/assert_macros.svh]
// assertion macros shared by the mask store rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at each rising edge outside reset
`define PBMS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked at each rising edge outside reset
`define PBMS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pbms_pkg.sv]
// shared types and constants for the packed bit mask store
// no dependencies; imported by every module of the block but pbms_mem
package pbms_pkg;

	// default store limits
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	// configuration port
	localparam int CFG_W   = 9;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PX  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_PX = 1'd1;
	localparam logic [CFG_W-1:0] WIDTH_PX_RST  = 9'd256;
	localparam logic [CFG_W-1:0] HEIGHT_PX_RST = 9'd256;

	// position compare width: a register value plus one bit for the limit
	localparam int CMP_W = CFG_W + 1;
	localparam int POS_W = 10;

	// stream payload widths
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 8;

	localparam logic [7:0] BYTE_ONES  = 8'hFF;
	localparam logic [7:0] BYTE_ZEROS = 8'h00;
	localparam logic [7:0] BIT_ONE    = 8'h01;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_FILL  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	// sweep sequencer status toward the datapath
	typedef struct packed {
		logic       busy;
		logic       done;
		logic       we;
		logic [7:0] wdata;
	} sweep_status_t;

endpackage

[sv/pbms_mem.sv]
// byte-wide single-port-write, single-port-read mask memory
// registered read port; uses nothing from the package
module pbms_mem #(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = 13
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              re,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, returns old data on a same-cycle write
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/pbms_locate.sv]
// position check and byte address generation for one pixel
// depends on pbms_pkg for field and compare widths
module pbms_locate
	import pbms_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int ADDR_W     = 13
) (
	input  logic [CFG_W-1:0]        width_px,
	input  logic [CFG_W-1:0]        height_px,
	input  logic signed [POS_W-1:0] x,
	input  logic signed [POS_W-1:0] y,
	output logic                    in_range,
	output logic [ADDR_W-1:0]       addr,
	output logic [2:0]              bit_sel
);

	localparam int STRIDE_MAX = (MAX_WIDTH + 7) / 8;
	localparam int STRIDE_W   = $clog2(STRIDE_MAX + 1);
	localparam int PROD_W     = (POS_W - 1) + STRIDE_W;
	localparam logic [CMP_W-1:0] MAXW_V = CMP_W'(MAX_WIDTH);
	localparam logic [CMP_W-1:0] MAXH_V = CMP_W'(MAX_HEIGHT);

	logic [CMP_W-1:0]  w_eff;
	logic [CMP_W-1:0]  h_eff;
	logic [CMP_W-1:0]  stride_full;
	logic [STRIDE_W-1:0] stride;
	logic [POS_W-2:0]  x_mag;
	logic [POS_W-2:0]  y_mag;
	logic [PROD_W:0]   byte_idx;

	// saturate the configured size to the store limits
	assign w_eff = ({1'b0, width_px} > MAXW_V) ? MAXW_V : {1'b0, width_px};
	assign h_eff = ({1'b0, height_px} > MAXH_V) ? MAXH_V : {1'b0, height_px};

	// row stride in bytes
	assign stride_full = (w_eff + CMP_W'(7)) >> 3;
	assign stride      = stride_full[STRIDE_W-1:0];

	assign x_mag = x[POS_W-2:0];
	assign y_mag = y[POS_W-2:0];

	// negative positions and positions past the edge are rejected
	assign in_range = !x[POS_W-1] && !y[POS_W-1]
		&& ({1'b0, x_mag} < w_eff) && ({1'b0, y_mag} < h_eff);

	// row start plus byte column
	assign byte_idx = (PROD_W + 1)'(y_mag * stride) + (PROD_W + 1)'(x_mag[POS_W-2:3]);
	assign addr     = byte_idx[ADDR_W-1:0];

	// leftmost pixel sits in the msb
	assign bit_sel = ~x_mag[2:0];

endmodule

[sv/pbms_sweep.sv]
// sequencer that writes one byte value over the whole memory
// depends on pbms_pkg; runs a clearing pass right after reset
module pbms_sweep
	import pbms_pkg::*;
#(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              fill_ones,
	output sweep_status_t     status,
	output logic [ADDR_W-1:0] addr
);

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	state_t            state_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        data_q;
	logic              last;

	assign last = (addr_q == LAST_ADDR);

	// one byte per cycle from address zero up to the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			addr_q  <= '0;
			data_q  <= BYTE_ZEROS;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SWEEP;
						addr_q  <= '0;
						data_q  <= fill_ones ? BYTE_ONES : BYTE_ZEROS;
					end
				end
				ST_SWEEP: begin
					if (last) begin
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + ADDR_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign status.busy  = (state_q == ST_SWEEP);
	assign status.we    = (state_q == ST_SWEEP);
	assign status.done  = (state_q == ST_SWEEP) && last;
	assign status.wdata = data_q;
	assign addr         = addr_q;

endmodule

[sv/packed_bit_mask_store_top.sv]
// a read or write request passes stage one, stage two and the output register
// throughput: one read or write request per cycle, set by the read-modify-write loop, while results
// are taken and no fill or clear is pending; a fill or clear sweeps all (MAX_WIDTH+7)/8*MAX_HEIGHT
// bytes, 8192 by default; reset: width and height go to 256 and a clearing pass of the store runs,
// during which no request is accepted; configuration writes are taken at any time
// depends on pbms_pkg, pbms_locate, pbms_sweep, pbms_mem and assert_macros.svh
`include "assert_macros.svh"

module packed_bit_mask_store_top
	import pbms_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_wdata,
	// request stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // mode[1:0], x[11:2], y[21:12], value[22]
	// result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // read_bit[0], out_of_range[1]
);

	localparam int STRIDE_MAX  = (MAX_WIDTH + 7) / 8;
	localparam int STORE_BYTES = STRIDE_MAX * MAX_HEIGHT;
	localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	// configuration registers
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_PX_RST;
			height_q <= HEIGHT_PX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH_PX:  width_q  <= cfg_wdata;
				REG_HEIGHT_PX: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// request unpacking
	mode_t                   in_mode;
	logic signed [POS_W-1:0] in_x;
	logic signed [POS_W-1:0] in_y;
	logic                    in_value;
	logic                    in_bulk;
	logic                    s_accept;

	assign in_mode  = mode_t'(s_axis_tdata[1:0]);
	assign in_x     = s_axis_tdata[11:2];
	assign in_y     = s_axis_tdata[21:12];
	assign in_value = s_axis_tdata[22];
	assign in_bulk  = (in_mode == MODE_FILL) || (in_mode == MODE_CLEAR);
	assign s_accept = s_axis_tvalid && s_axis_tready;

	// position check and address
	logic              loc_in_range;
	logic [ADDR_W-1:0] loc_addr;
	logic [2:0]        loc_bit;

	pbms_locate #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.ADDR_W     (ADDR_W)
	) u_locate (
		.width_px  (width_q),
		.height_px (height_q),
		.x         (in_x),
		.y         (in_y),
		.in_range  (loc_in_range),
		.addr      (loc_addr),
		.bit_sel   (loc_bit)
	);

	// pipeline registers
	logic              valid_s1;
	mode_t             mode_s1;
	logic              in_range_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [2:0]        bit_s1;
	logic              value_s1;

	logic              valid_s2;
	mode_t             mode_s2;
	logic              in_range_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [2:0]        bit_s2;
	logic              value_s2;

	logic              out_valid_q;
	logic              out_read_bit_q;
	logic              out_oor_q;

	// forwarding of the byte written in the cycle the next request read
	logic              fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [7:0]        fwd_data_q;

	logic              swept_q;
	logic              bulk_s1;
	logic              bulk_s2;
	logic              hold;
	logic              adv;

	sweep_status_t     sweep_st;
	logic [ADDR_W-1:0] sweep_addr;
	logic              sweep_start;

	logic [7:0]        rd_data;
	logic [7:0]        cur_byte;
	logic [7:0]        bit_mask;
	logic [7:0]        new_byte;
	logic              item_we;
	logic              res_read_bit;
	logic              res_oor;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_wr_addr;
	logic [7:0]        mem_wr_data;

	assign bulk_s1 = valid_s1 && ((mode_s1 == MODE_FILL) || (mode_s1 == MODE_CLEAR));
	assign bulk_s2 = valid_s2 && ((mode_s2 == MODE_FILL) || (mode_s2 == MODE_CLEAR));

	// a fill or clear waits in stage two until its sweep is over
	assign hold = bulk_s2 && !swept_q;
	assign adv  = (!out_valid_q || m_axis_tready) && !hold;

	// nothing enters behind a fill or clear until it has finished
	assign s_axis_tready = adv && !sweep_st.busy && !bulk_s1 && !bulk_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_accept;
			valid_s2 <= valid_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1     <= in_mode;
			in_range_s1 <= loc_in_range;
			addr_s1     <= loc_addr;
			bit_s1      <= loc_bit;
			value_s1    <= in_value;
			mode_s2     <= mode_s1;
			in_range_s2 <= in_range_s1;
			addr_s2     <= addr_s1;
			bit_s2      <= bit_s1;
			value_s2    <= value_s1;
		end
	end

	// sweep handshake for the request held in stage two
	assign sweep_start = bulk_s2 && !swept_q && !sweep_st.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swept_q <= 1'b0;
		end else if (adv) begin
			swept_q <= 1'b0;
		end else if (sweep_st.done && bulk_s2) begin
			swept_q <= 1'b1;
		end
	end

	pbms_sweep #(
		.DEPTH  (STORE_BYTES),
		.ADDR_W (ADDR_W)
	) u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (sweep_start),
		.fill_ones (mode_s2 == MODE_FILL),
		.status    (sweep_st),
		.addr      (sweep_addr)
	);

	// read-modify-write of one byte in stage two
	assign cur_byte = (fwd_valid_q && (fwd_addr_q == addr_s2)) ? fwd_data_q : rd_data;
	assign bit_mask = BIT_ONE << bit_s2;
	assign new_byte = value_s2 ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
	assign item_we  = adv && valid_s2 && (mode_s2 == MODE_WRITE) && in_range_s2;

	assign res_read_bit = (mode_s2 == MODE_READ) && in_range_s2 && cur_byte[bit_s2];
	assign res_oor      = ((mode_s2 == MODE_READ) || (mode_s2 == MODE_WRITE)) && !in_range_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (adv) begin
			fwd_valid_q <= item_we;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_addr_q <= addr_s2;
			fwd_data_q <= new_byte;
		end
	end

	// memory port sharing between the sweep and single-byte writes
	assign mem_we      = sweep_st.we || item_we;
	assign mem_wr_addr = sweep_st.we ? sweep_addr : addr_s2;
	assign mem_wr_data = sweep_st.we ? sweep_st.wdata : new_byte;

	pbms_mem #(
		.DEPTH  (STORE_BYTES),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.re      (adv),
		.rd_addr (addr_s1),
		.rd_data (rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_read_bit_q <= res_read_bit;
			out_oor_q      <= res_oor;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, out_oor_q, out_read_bit_q};

	// checks
	`PBMS_ASSERT_IMP(a_no_accept_in_sweep, clk, arst_n, sweep_st.busy, !s_axis_tready, "request accepted during sweep")
	`PBMS_ASSERT_IMP(a_no_byte_write_in_sweep, clk, arst_n, sweep_st.busy, !item_we, "byte write collides with sweep")
	`PBMS_ASSERT_NXT(a_bulk_blocks_next, clk, arst_n, s_accept && in_bulk, !s_axis_tready, "request accepted behind fill or clear")
	`PBMS_ASSERT_NXT(a_result_held, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

endmodule

[bench/packed_bit_mask_store_checker.sv]
`timescale 1ns / 1ps
// result checker for the packed bit mask store: mirrors the mask and the size
// registers, predicts every result and compares it when it is accepted
// depends on pbms_pkg
module packed_bit_mask_store_checker
	import pbms_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // mode[1:0], x[11:2], y[21:12], value[22]
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // read_bit[0], out_of_range[1]
	output int                     fail_count,
	output int                     pending_count
);

	localparam int STRIDE_MAX  = (MAX_WIDTH + 7) / 8;
	localparam int STORE_BYTES = STRIDE_MAX * MAX_HEIGHT;

	typedef struct packed {
		logic       value;
		logic [9:0] y;
		logic [9:0] x;
		mode_t      mode;
	} mask_req_t;

	typedef struct packed {
		logic out_of_range;
		logic read_bit;
	} mask_result_t;

	logic [7:0]       mask_bytes [STORE_BYTES];
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	mask_result_t     result_q [$];
	mask_req_t        req;
	mask_result_t     got;
	mask_result_t     want;

	// register value above the store limit saturates to the limit
	function automatic int clamp_size(input logic [CFG_W-1:0] size, input int limit);
		return (int'(size) > limit) ? limit : int'(size);
	endfunction

	// applies one request to the mirrored mask and returns its result
	function automatic mask_result_t apply_mask_request(input mask_req_t r);
		mask_result_t res;
		int           w;
		int           h;
		int           idx;
		logic [2:0]   bit_sel;
		res = '0;
		w = clamp_size(width_reg, MAX_WIDTH);
		h = clamp_size(height_reg, MAX_HEIGHT);
		case (r.mode)
			MODE_FILL: begin
				foreach (mask_bytes[i]) mask_bytes[i] = BYTE_ONES;
			end
			MODE_CLEAR: begin
				foreach (mask_bytes[i]) mask_bytes[i] = BYTE_ZEROS;
			end
			default: begin
				// negative or past the configured edge: no access
				if (r.x[9] || r.y[9] || int'(r.x[8:0]) >= w || int'(r.y[8:0]) >= h) begin
					res.out_of_range = 1'b1;
				end else begin
					idx = int'(r.y[8:0]) * ((w + 7) / 8) + int'(r.x[8:0]) / 8;
					if (idx >= STORE_BYTES) begin
						res.out_of_range = 1'b1;
					end else begin
						// leftmost pixel sits in the top bit of the byte
						bit_sel = 3'd7 - r.x[2:0];
						if (r.mode == MODE_READ)
							res.read_bit = mask_bytes[idx][bit_sel];
						else
							mask_bytes[idx][bit_sel] = r.value;
					end
				end
			end
		endcase
		return res;
	endfunction

	// watch both streams and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (mask_bytes[i]) mask_bytes[i] = BYTE_ZEROS;
			width_reg = WIDTH_PX_RST;
			height_reg = HEIGHT_PX_RST;
			result_q.delete();
			fail_count = 0;
			pending_count <= 0;
		end else begin
			// compare an accepted result with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got = mask_result_t'(m_axis_tdata[1:0]);
				if (result_q.size() == 0) begin
					$display("%0t: result with none expected, got read_bit %0d out_of_range %0d",
						$time, got.read_bit, got.out_of_range);
					fail_count = fail_count + 1;
				end else begin
					want = result_q.pop_front();
					if (got.read_bit !== want.read_bit) begin
						$display("%0t: read_bit expected %0d, got %0d",
							$time, want.read_bit, got.read_bit);
						fail_count = fail_count + 1;
					end
					if (got.out_of_range !== want.out_of_range) begin
						$display("%0t: out_of_range expected %0d, got %0d",
							$time, want.out_of_range, got.out_of_range);
						fail_count = fail_count + 1;
					end
				end
			end
			// predict the result of an accepted request
			if (s_axis_tvalid && s_axis_tready) begin
				req = mask_req_t'(s_axis_tdata[22:0]);
				result_q.push_back(apply_mask_request(req));
			end
			// size register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH_PX: width_reg = cfg_wdata;
					REG_HEIGHT_PX: height_reg = cfg_wdata;
					default: ;
				endcase
			end
			pending_count <= result_q.size();
		end
	end

endmodule

[bench/packed_bit_mask_store_top_test.sv]
`timescale 1ns / 1ps
// stimulus and verdict for the packed bit mask store: size register writes,
// directed and random requests, random stalls on both streams
// depends on pbms_pkg, packed_bit_mask_store_top and packed_bit_mask_store_checker
module packed_bit_mask_store_top_test;
	import pbms_pkg::*;

	localparam int WATCHDOG_LIMIT = 50000;
	localparam int LONG_HOLD      = 200;
	localparam int PHASES         = 8;
	localparam int HISTORY_DEPTH  = 16;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_WIDTH_PX;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // mode[1:0], x[11:2], y[21:12], value[22]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;       // read_bit[0], out_of_range[1]
	int                     fail_count;
	int                     pending_count;
	int                     quiet_cycles = 0;
	logic                   idle_enable = 1'b1;
	logic                   sink_hold_req = 1'b0;
	logic [9:0]             written_x [$];
	logic [9:0]             written_y [$];

	always #5 clk = ~clk;

	packed_bit_mask_store_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	packed_bit_mask_store_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold on request
	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				sink_hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 14);
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// offer one request, with an occasional gap in front, until it is taken
	task automatic send_request(input mode_t mode, input logic [9:0] x, input logic [9:0] y,
			input logic value);
		int gap;
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, value, y, x, mode};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// stop offering and wait for every predicted result
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		repeat (8) @(posedge clk);
	endtask

	// width and height writes, back to back
	task automatic write_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH_PX;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT_PX;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly inside the mask, sometimes on the edge, negative or anywhere
	function automatic logic [9:0] pick_coord(input int span);
		int roll;
		roll = $urandom_range(0, 9);
		if (span > 0 && roll < 7)
			return 10'($urandom_range(0, span - 1));
		else if (roll == 7)
			return 10'(span);
		else if (roll == 8)
			return 10'($urandom_range(512, 1023));
		else
			return 10'($urandom);
	endfunction

	// random requests; reads often revisit a recently written pixel
	task automatic send_random_requests(input int count, input int w_eff, input int h_eff);
		int         roll;
		int         pick;
		logic [9:0] x;
		logic [9:0] y;
		mode_t      mode;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				mode = MODE_FILL;
			else if (roll < 6)
				mode = MODE_CLEAR;
			else if (roll < 50)
				mode = MODE_WRITE;
			else
				mode = MODE_READ;
			x = pick_coord(w_eff);
			y = pick_coord(h_eff);
			if (mode == MODE_READ && written_x.size() > 0 && $urandom_range(0, 1) == 1) begin
				pick = $urandom_range(0, written_x.size() - 1);
				x = written_x[pick];
				y = written_y[pick];
			end
			if (mode == MODE_WRITE) begin
				written_x.push_back(x);
				written_y.push_back(y);
				if (written_x.size() > HISTORY_DEPTH) begin
					void'(written_x.pop_front());
					void'(written_y.pop_front());
				end
			end
			send_request(mode, x, y, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin : stimulus
		int w_set [PHASES] = '{1, 0, 511, 13, 256, 1, 200, 37};
		int h_set [PHASES] = '{1, 0, 511, 5, 1, 256, 300, 9};
		int w_eff;
		int h_eff;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed requests at the reset size of 256 by 256
		send_request(MODE_READ, 10'd0, 10'd0, 1'b0);
		send_request(MODE_WRITE, 10'd255, 10'd255, 1'b1);
		send_request(MODE_READ, 10'd255, 10'd255, 1'b0);
		send_request(MODE_READ, 10'd254, 10'd255, 1'b1);
		// just past the right and bottom edges
		send_request(MODE_READ, 10'd256, 10'd0, 1'b0);
		send_request(MODE_READ, 10'd0, 10'd256, 1'b0);
		// negative positions, smallest and minus one
		send_request(MODE_READ, 10'h3FF, 10'd0, 1'b0);
		send_request(MODE_WRITE, 10'd0, 10'h200, 1'b1);
		send_request(MODE_WRITE, 10'h200, 10'h3FF, 1'b1);
		send_request(MODE_READ, 10'd511, 10'd511, 1'b1);
		send_request(MODE_WRITE, 10'd7, 10'd0, 1'b1);
		send_request(MODE_READ, 10'd7, 10'd0, 1'b0);
		// fill, then punch a hole and read around it
		send_request(MODE_FILL, 10'd0, 10'd0, 1'b0);
		send_request(MODE_READ, 10'd100, 10'd200, 1'b0);
		send_request(MODE_WRITE, 10'd100, 10'd200, 1'b0);
		send_request(MODE_READ, 10'd100, 10'd200, 1'b1);
		send_request(MODE_READ, 10'd101, 10'd200, 1'b0);
		send_request(MODE_CLEAR, 10'h3FF, 10'h3FF, 1'b1);
		send_request(MODE_READ, 10'd255, 10'd255, 1'b0);
		drain_results();

		// one size setting per phase; zero, one, full and oversized among them
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				w_set[p] = $urandom_range(0, 511);
				h_set[p] = $urandom_range(0, 511);
				idle_enable = 1'b0;
			end
			write_size(CFG_W'(w_set[p]), CFG_W'(h_set[p]));
			w_eff = (w_set[p] > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_set[p];
			h_eff = (h_set[p] > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h_set[p];
			if (p == 3) begin
				// result side holds off while requests keep coming
				sink_hold_req = 1'b1;
				send_random_requests(20, w_eff, h_eff);
			end
			send_random_requests(45, w_eff, h_eff);
			drain_results();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/pbms_pkg.sv
sv/pbms_mem.sv
sv/pbms_locate.sv
sv/pbms_sweep.sv
sv/packed_bit_mask_store_top.sv
bench/packed_bit_mask_store_checker.sv
bench/packed_bit_mask_store_top_test.sv
